>>> design/assert_macros.svh
// Assertion helpers used by the sorter control logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ISORT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// If ante holds, cons must hold in the next cycle.
`define ISORT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/isort_pkg.sv
`default_nettype none

package isort_pkg;

   // Number of cells in the chain (largest set that is kept).
   localparam int DEPTH = 64;
   localparam int DATA_W = 32;
   // Count must hold DEPTH itself.
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef logic signed [DATA_W-1:0] value_type;
   typedef logic [CNT_W-1:0] count_type;

   // Command broadcast to every cell.
   typedef struct packed {
      logic      insert;  // place key in order, larger entries move up
      logic      shift;   // move every entry down one place
      value_type key;
   } cell_cmd_type;

endpackage

`default_nettype wire

>>> design/insertion_sorter.sv
// Streaming insertion sorter for signed 32-bit values.
// Input (req_): one value per transfer in req_tdata, req_tlast marks the last
// value of a set. Output (rsp_): the set in ascending order, rsp_tlast on the
// final result, rsp_tuser set on every result of a set that had more values
// than the 64-entry cell chain holds (the extra values are dropped).
// While a set is loading, one value is taken every cycle: every cell compares
// its entry with the incoming value at once and larger entries step up one
// cell, so an insert is written at its transfer regardless of position.
// The cycle after the transfer with req_tlast, rsp_tvalid rises and the chain
// shifts down one cell per result transfer until every kept value has gone
// out. req_tready is low during the drain, so the next set is taken only
// after the final result of this one.
// If the receiver stalls, the current result is held in cell 0 unchanged.
// Reset empties the list, clears the overflow flag and returns to loading;
// cell contents are not cleared, occupancy comes from the fill count.
`default_nettype none

module insertion_sorter (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // [31:0] value
   input  wire         req_tlast,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] sorted_value
   output logic        rsp_tlast,
   output logic        rsp_tuser    // [0] overflow
);
   import isort_pkg::*;

   cell_cmd_type cmd;
   count_type    count;
   value_type    value_w [DEPTH];
   logic         gt_w    [DEPTH];
   logic         occ_w   [DEPTH];

   isort_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_last     (req_tlast),
      .req_value    (value_type'(req_tdata)),
      .req_ready    (req_tready),
      .rsp_ready    (rsp_tready),
      .rsp_valid    (rsp_tvalid),
      .rsp_last     (rsp_tlast),
      .rsp_overflow (rsp_tuser),
      .cmd          (cmd),
      .count        (count)
   );

   // Chain of cells; entries below count are occupied
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic      prev_occ;
      logic      prev_gt;
      value_type prev_value;
      value_type next_value;

      assign occ_w[i] = (count > CNT_W'(i));

      if (i == 0) begin : g_first
         assign prev_occ   = 1'b1;
         assign prev_gt    = 1'b0;
         assign prev_value = '0;
      end else begin : g_mid
         assign prev_occ   = occ_w[i-1];
         assign prev_gt    = gt_w[i-1];
         assign prev_value = value_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_top
         assign next_value = '0;
      end else begin : g_below
         assign next_value = value_w[i+1];
      end

      isort_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .occ        (occ_w[i]),
         .prev_occ   (prev_occ),
         .prev_gt    (prev_gt),
         .prev_value (prev_value),
         .next_value (next_value),
         .value      (value_w[i]),
         .gt         (gt_w[i])
      );
   end

   // Smallest entry sits in cell 0
   assign rsp_tdata = 32'(value_w[0]);

endmodule

`default_nettype wire

>>> design/isort_cell.sv
`default_nettype none

module isort_cell (
   input  wire                          clock,
   input  wire isort_pkg::cell_cmd_type cmd,
   input  wire                          occ,         // this cell holds an entry
   input  wire                          prev_occ,    // lower neighbor holds an entry
   input  wire                          prev_gt,     // lower neighbor's entry > key
   input  wire isort_pkg::value_type    prev_value,
   input  wire isort_pkg::value_type    next_value,  // upper neighbor's entry
   output isort_pkg::value_type         value,
   output logic                         gt
);
   import isort_pkg::*;

   value_type value_ff;
   value_type value_in;

   // Strict compare keeps equal values in arrival order.
   assign gt = occ && (value_ff > cmd.key);

   // Next entry: shift down on drain, ripple up or take the key on insert
   always_comb begin
      value_in = value_ff;
      if (cmd.shift) begin
         value_in = next_value;
      end else if (cmd.insert) begin
         if (prev_gt) begin
            value_in = prev_value;
         end else if ((!occ || gt) && prev_occ) begin
            value_in = cmd.key;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

>>> design/isort_ctrl.sv
`default_nettype none

module isort_ctrl (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   input  wire                       req_last,
   input  wire isort_pkg::value_type req_value,
   output logic                      req_ready,
   input  wire                       rsp_ready,
   output logic                      rsp_valid,
   output logic                      rsp_last,
   output logic                      rsp_overflow,
   output isort_pkg::cell_cmd_type   cmd,
   output isort_pkg::count_type      count
);
   import isort_pkg::*;

   localparam logic ST_FILL  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic      state_ff, state_in;
   count_type count_ff, count_in;
   logic      overflow_ff, overflow_in;

   logic req_fire;
   logic rsp_fire;
   logic full;
   logic final_one;

   assign req_ready = (state_ff == ST_FILL);
   assign rsp_valid = (state_ff == ST_DRAIN);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign final_one = (count_ff == CNT_W'(1));

   // Cell commands
   assign cmd.insert = req_fire && !full;
   assign cmd.shift  = rsp_fire;
   assign cmd.key    = req_value;

   // Occupancy count, overflow flag and fill/drain state
   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      state_in    = state_ff;
      if (req_fire) begin
         if (full) begin
            overflow_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
         if (req_last) begin
            state_in = ST_DRAIN;
         end
      end else if (rsp_fire) begin
         count_in = count_ff - CNT_W'(1);
         if (final_one) begin
            overflow_in = 1'b0;
            state_in    = ST_FILL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_FILL;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

   assign rsp_last     = final_one;
   assign rsp_overflow = overflow_ff;
   assign count        = count_ff;

   `include "assert_macros.svh"

   `ISORT_ASSERT(a_count_range, clock, reset, count_ff <= CNT_W'(DEPTH),
                 "count above depth")
   `ISORT_ASSERT(a_drain_nonempty, clock, reset, !rsp_valid || (count_ff != '0),
                 "drain on empty list")
   `ISORT_ASSERT(a_cmd_excl, clock, reset, !(cmd.insert && cmd.shift),
                 "insert and shift together")
   `ISORT_ASSERT_NEXT(a_final_empties, clock, reset, rsp_fire && rsp_last,
                      (count_ff == '0) && req_ready && !overflow_ff,
                      "list not emptied after final result")

endmodule

`default_nettype wire

>>> tb/testbench.sv
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import isort_pkg::*;

   localparam int CYCLE_LIMIT = 100000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 2 * DEPTH + 10;

   // how random values are drawn for a set
   typedef enum int {MIX_FULL, MIX_DUPES, MIX_EDGES} value_mix_type;

   // one sorted value as the block should return it
   typedef struct {
      value_type sorted_value;
      logic      final_res;
      logic      overflow;
   } sorted_entry_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] value
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;       // [31:0] sorted_value
   logic        rsp_tlast;
   logic        rsp_tuser;       // [0] overflow

   // predictor state: current set in ascending order and its overflow flag
   value_type        kept_list[$];
   logic             kept_overflow = 1'b0;
   sorted_entry_type pending_sorted[$];
   sorted_entry_type want;

   int tx_idle_pct = 0;
   int rx_stall_pct = 0;
   bit hold_trigger = 1'b0;
   bit hold_seen = 1'b0;
   int hold_left = 0;

   int error_count = 0;
   int cycle_count = 0;
   int values_sent = 0;
   int sets_sent = 0;
   int overflow_sets = 0;
   int results_checked = 0;

   insertion_sorter DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("cycle limit reached with %0d results outstanding", pending_sorted.size());
         $display("FAILURE");
         $finish;
      end
   end

   // receiver: random stalls, or a long hold-off when the trigger toggles
   always @(posedge clock) begin
      if (hold_trigger != hold_seen) begin
         hold_seen = hold_trigger;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // result check against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_sorted.size() == 0) begin
            $error("unexpected result transfer, sorted_value %0d", $signed(rsp_tdata));
            error_count++;
         end else begin
            want = pending_sorted.pop_front();
            results_checked++;
            if (rsp_tdata !== want.sorted_value) begin
               $error("sorted_value: expected %0d, got %0d",
                      want.sorted_value, $signed(rsp_tdata));
               error_count++;
            end
            if (rsp_tlast !== want.final_res) begin
               $error("final_res: expected %0b, got %0b", want.final_res, rsp_tlast);
               error_count++;
            end
            if (rsp_tuser !== want.overflow) begin
               $error("overflow: expected %0b, got %0b", want.overflow, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   // insert one accepted value; on last, queue the whole sorted set
   function automatic void sort_into_list(value_type v, logic is_last);
      int pos;
      int n;
      if (kept_list.size() < DEPTH) begin
         pos = kept_list.size();
         while (pos > 0 && kept_list[pos-1] > v) pos--;
         kept_list.insert(pos, v);
      end else begin
         kept_overflow = 1'b1;
      end
      if (is_last) begin
         n = kept_list.size();
         for (int i = 0; i < n; i++)
            pending_sorted.push_back('{kept_list[i], (i == n - 1), kept_overflow});
         if (kept_overflow) overflow_sets++;
         sets_sent++;
         kept_list.delete();
         kept_overflow = 1'b0;
      end
   endfunction

   function automatic value_type pick_value(value_mix_type mix);
      case (mix)
         MIX_DUPES: pick_value = $signed($urandom_range(15)) - 8;
         MIX_EDGES: begin
            case ($urandom_range(5))
               0: pick_value = 32'h8000_0000;
               1: pick_value = 32'h7FFF_FFFF;
               2: pick_value = '0;
               3: pick_value = '1;
               4: pick_value = 32'sd1;
               default: pick_value = $urandom;
            endcase
         end
         default: pick_value = $urandom;
      endcase
   endfunction

   // set length: mostly short, sometimes medium
   function automatic int pick_length();
      int roll;
      roll = $urandom_range(99);
      if (roll < 85) pick_length = $urandom_range(1, 8);
      else pick_length = $urandom_range(9, 16);
   endfunction

   // one transfer on the input side, with a random gap in front
   task automatic send_item(input value_type v, input logic is_last);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      req_tlast  <= is_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sort_into_list(v, is_last);
      values_sent++;
   endtask

   task automatic send_random_set(input int len, input value_mix_type mix);
      for (int i = 0; i < len; i++)
         send_item(pick_value(mix), (i == len - 1));
   endtask

   // sender goes quiet until every queued result has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_sorted.size() != 0) @(posedge clock);
   endtask

   // extremes, single-value set, reversed order, runs of equal values
   task automatic test_directed();
      value_type edge_vals[9];
      tx_idle_pct = 0;
      rx_stall_pct <= 0;
      edge_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h1,
                    32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA};
      foreach (edge_vals[i]) send_item(edge_vals[i], (i == 8));
      send_item(32'sd7, 1'b1);
      for (int i = 5; i >= 1; i--) send_item(value_type'(i), (i == 1));
      send_item(32'sd42, 1'b0);
      send_item(32'sd42, 1'b0);
      send_item(32'sd41, 1'b0);
      send_item(32'sd42, 1'b0);
      send_item(32'sd43, 1'b1);
      wait_drained();
   endtask

   // store filled, several values dropped including the last, then flag cleared
   task automatic test_overflow();
      tx_idle_pct = 10;
      rx_stall_pct <= 30;
      send_random_set(DEPTH + 3, MIX_DUPES);
      send_random_set(2, MIX_FULL);
      wait_drained();
   endtask

   task automatic random_phase(input int tx_pct, input int rx_pct, input int n_values);
      int start;
      tx_idle_pct = tx_pct;
      rx_stall_pct <= rx_pct;
      start = values_sent;
      while (values_sent - start < n_values)
         send_random_set(pick_length(), value_mix_type'($urandom_range(2)));
      wait_drained();
   endtask

   task automatic test_random();
      random_phase(0, 0, 15);
      random_phase(66, 0, 15);
      random_phase(0, 66, 15);
      random_phase(8, 8, 15);
   endtask

   // receiver holds off while the sender keeps offering sets
   task automatic test_backpressure();
      tx_idle_pct = 0;
      rx_stall_pct <= 0;
      hold_trigger <= ~hold_trigger;
      send_random_set(8, MIX_FULL);
      send_random_set(6, MIX_DUPES);
      send_random_set(4, MIX_EDGES);
      wait_drained();
   endtask

   // sender stops between sets until everything has come back
   task automatic test_pause();
      tx_idle_pct = 20;
      rx_stall_pct <= 20;
      send_random_set(7, MIX_FULL);
      wait_drained();
      send_random_set(3, MIX_EDGES);
      wait_drained();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_overflow();
      test_random();
      test_backpressure();
      test_pause();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_sorted.size() != 0) begin
         $error("%0d expected results never arrived", pending_sorted.size());
         error_count++;
      end

      $display("sorted %0d sets from %0d values (%0d with dropped values), %0d results checked",
               sets_sent, values_sent, overflow_sets, results_checked);
      $display("ran with steady flow, sender gaps, receiver stalls and a long hold-off");
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> files.f
+incdir+design
design/isort_pkg.sv
design/isort_cell.sv
design/isort_ctrl.sv
design/insertion_sorter.sv
tb/testbench.sv
